// File: src/sha1sh_pkg.sv
package sha1sh_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [4:0] hash_t;

	localparam hash_t IV = '{
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam logic [5:0] PAD_POS   = 6'd56;
	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [6:0] FOLD_RND  = 7'd80;

	typedef struct packed {
		logic       push;
		logic [7:0] data;
		logic       reinit;
	} core_ctrl_t;

	typedef struct packed {
		logic       busy;
		logic [5:0] pos;
	} core_stat_t;

endpackage

// File: src/sha1sh_core.sv
module sha1sh_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1sh_pkg::core_ctrl_t ctrl,
	output sha1sh_pkg::core_stat_t stat,
	output sha1sh_pkg::hash_t      hash
);
	import sha1sh_pkg::*;

	logic [5:0]  pos_q;
	logic        busy_q;
	logic [6:0]  round_q;
	hash_t       h_q;
	logic [23:0] part_q;
	word_t       sched_q [16];
	word_t       a_q, b_q, c_q, d_q, e_q;

	word_t f, k, x, w_new, t;
	logic  push_ok, round_en;

	assign push_ok  = ctrl.push && !busy_q;
	assign round_en = busy_q && (round_q != FOLD_RND);

	always_comb begin
		priority if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		x     = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
		w_new = {x[30:0], x[31]};
		t     = {a_q[26:0], a_q[31:27]} + f + e_q + k + sched_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			busy_q  <= 1'b0;
			round_q <= '0;
			h_q     <= IV;
		end else if (busy_q) begin
			if (round_q == FOLD_RND) begin
				busy_q <= 1'b0;
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			round_q <= round_q + 7'd1;
		end else if (ctrl.reinit) begin
			pos_q <= '0;
			h_q   <= IV;
		end else if (push_ok) begin
			pos_q <= pos_q + 6'd1;
			if (pos_q == LAST_POS) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end
		end
	end

	// message schedule window: sched_q[0] is the word of the current round
	always_ff @(posedge clk) begin
		if (round_en) begin
			for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i + 1];
			sched_q[15] <= w_new;
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end else if (push_ok) begin
			part_q <= {part_q[15:0], ctrl.data};
			if (pos_q[1:0] == 2'd3) begin
				for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i + 1];
				sched_q[15] <= {part_q, ctrl.data};
			end
			if (pos_q == LAST_POS) begin
				a_q <= h_q[0];
				b_q <= h_q[1];
				c_q <= h_q[2];
				d_q <= h_q[3];
				e_q <= h_q[4];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.pos  = pos_q;
	assign hash      = h_q;

endmodule

// File: src/sha1_stream_hash_top.sv
// SHA-1 stream hasher.
// Input channel (in_valid/in_ready): one transaction carries data_byte with
// byte_present, and finish to close the message. The 64th byte of a block
// starts the compression, 80 rounds on one shared round unit followed by a
// fold into the chaining words, during which in_ready is low.
// On finish the block feeds its own padding bytes (0x80, zeros to offset 56,
// 64-bit bit length) at one byte a cycle while no compression runs, 9 to 72
// bytes with one or two compressions, then hands the digest over and
// reinitialises. From the finish transaction until then, in_ready stays low.
// Output channel (out_valid/out_ready): five transactions, digest_word H0
// first, last_word high on the fifth. The digest sits in its own buffer, so
// the next message is taken while it drains; a second finish waits for the
// buffer to empty when the receiver stalls.
// Reset (arst_n low) loads the initial hash values and clears the byte count,
// block position and output buffer; no result is pending afterwards.
module sha1_stream_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        finish,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic        last_word
);
	import sha1sh_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PAD   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	localparam logic [1:0] PP_MARK = 2'd0;
	localparam logic [1:0] PP_ZERO = 2'd1;
	localparam logic [1:0] PP_LEN  = 2'd2;

	logic [1:0]  state_q;
	logic [1:0]  pp_q;
	logic [2:0]  lcnt_q;
	logic [60:0] cnt_q;
	logic [63:0] len_q;
	word_t       ob_q [5];
	logic [2:0]  ob_left_q;

	core_ctrl_t ctrl;
	core_stat_t stat;
	hash_t      hash;

	logic        in_acc, out_acc;
	logic [60:0] cnt_next;

	sha1sh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.hash   (hash)
	);

	assign in_ready = (state_q == S_IDLE) && !stat.busy;
	assign in_acc   = in_valid && in_ready;
	assign cnt_next = cnt_q + {60'd0, byte_present};

	assign out_valid   = (ob_left_q != 3'd0);
	assign out_acc     = out_valid && out_ready;
	assign digest_word = ob_q[0];
	assign last_word   = (ob_left_q == 3'd1);

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			S_IDLE: begin
				ctrl.push = in_acc && byte_present;
				ctrl.data = data_byte;
			end
			S_PAD: begin
				if (!stat.busy) begin
					unique case (pp_q)
						PP_MARK: begin
							ctrl.push = 1'b1;
							ctrl.data = 8'h80;
						end
						PP_ZERO: ctrl.push = (stat.pos != PAD_POS);
						PP_LEN: begin
							ctrl.push = 1'b1;
							ctrl.data = len_q[63:56];
						end
						default: ctrl.push = 1'b0;
					endcase
				end
			end
			S_DRAIN: ctrl.reinit = !stat.busy && (ob_left_q == 3'd0);
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pp_q      <= PP_MARK;
			lcnt_q    <= '0;
			cnt_q     <= '0;
			ob_left_q <= '0;
		end else begin
			if (ctrl.reinit) begin
				ob_left_q <= 3'd5;
			end else if (out_acc) begin
				ob_left_q <= ob_left_q - 3'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q <= cnt_next;
						if (finish) begin
							state_q <= S_PAD;
							pp_q    <= PP_MARK;
							lcnt_q  <= '0;
						end
					end
				end
				S_PAD: begin
					if (!stat.busy) begin
						unique case (pp_q)
							PP_MARK: pp_q <= PP_ZERO;
							PP_ZERO: if (stat.pos == PAD_POS) pp_q <= PP_LEN;
							PP_LEN: begin
								lcnt_q <= lcnt_q + 3'd1;
								if (lcnt_q == 3'd7) state_q <= S_DRAIN;
							end
							default: pp_q <= PP_MARK;
						endcase
					end
				end
				S_DRAIN: begin
					if (ctrl.reinit) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && finish) begin
			len_q <= {cnt_next, 3'b000};
		end else if (state_q == S_PAD && pp_q == PP_LEN && !stat.busy) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (ctrl.reinit) begin
			for (int i = 0; i < 5; i++) ob_q[i] <= hash[i];
		end else if (out_acc) begin
			for (int i = 0; i < 4; i++) ob_q[i] <= ob_q[i + 1];
		end
	end

endmodule
